// ----- rtl/bij_pkg.sv -----
package bij_pkg;

  localparam int unsigned IvW   = 32;  // Q16.16 interval
  localparam int unsigned FacW  = 16;  // Q4.12 factors; random fraction is Q0.16
  localparam int unsigned MulAW = 36;  // widest multiplicand: spread half-width
  localparam int unsigned MulPW = MulAW + FacW;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [FacW-1:0] OneQ412 = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_INTERVAL    = 4'd0,
    REG_MAX_INTERVAL    = 4'd1,
    REG_GROWTH_FACTOR   = 4'd2,
    REG_JITTER_FRACTION = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_DRAW  = 1'b0,
    CMD_RESET = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [IvW-1:0]  min_interval;
    logic [IvW-1:0]  max_interval;
    logic [FacW-1:0] growth_factor;
    logic [FacW-1:0] jitter_fraction;
    logic            restart;  // set in the cycle after a register write
  } cfg_t;

endpackage

// ----- rtl/backoff_interval_jitter_top.sv -----
// Channel  Handshake                  Payload
// in       in_valid_i / in_stall_o    cmd_i, random_fraction_i
// out      out_valid_o / out_stall_i  resend_delay_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Between accept and the next accept a draw makes three passes through
// the one 36x16 multiplier (I*J, half*r, I*B), a grow step and an output step.
// A reset command stays idle. Input stalls the cycle after a register write.
// Reset restores the register defaults and an interval of 0.5 s.
// A result waits in the output register while out_stall_i is high; the next
// item is still accepted, and its result waits in the output step.
module backoff_interval_jitter_top
  import bij_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [FacW-1:0]    random_fraction_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IvW-1:0]     resend_delay_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [IvW-1:0]     cfg_data_i
);

  cfg_t cfg;

  bij_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bij_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .resend_delay_o    (resend_delay_o)
  );

endmodule

// ----- rtl/bij_mul.sv -----
module bij_mul
  import bij_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MulAW-1:0]  a_i,
  input  logic [FacW-1:0]   b_i,
  output logic [MulPW-1:0]  prod_o
);

  logic [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= MulPW'(a_i) * MulPW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/bij_cfg.sv -----
module bij_cfg
  import bij_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [IvW-1:0]     cfg_data_i,
  output cfg_t               cfg_o
);

  logic [IvW-1:0]  min_q, min_d;
  logic [IvW-1:0]  max_q, max_d;
  logic [FacW-1:0] grow_q, grow_d;
  logic [FacW-1:0] jit_q, jit_d;
  logic            restart_q, restart_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_d     = min_q;
    max_d     = max_q;
    grow_d    = grow_q;
    jit_d     = jit_q;
    restart_d = 1'b0;
    if (cfg_valid_i) begin
      restart_d = 1'b1;
      case (cfg_reg_e'(cfg_index_i))
        REG_MIN_INTERVAL:    min_d = cfg_data_i;
        REG_MAX_INTERVAL:    max_d = cfg_data_i;
        REG_GROWTH_FACTOR: begin
          // growth below 1.0 is pinned to 1.0
          grow_d = (cfg_data_i[FacW-1:0] < OneQ412) ? OneQ412 : cfg_data_i[FacW-1:0];
        end
        REG_JITTER_FRACTION: jit_d = cfg_data_i[FacW-1:0];
        default:             restart_d = 1'b0;  // unknown index: no effect
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= 32'd32768;
      max_q     <= 32'd983040;
      grow_q    <= 16'd6144;
      jit_q     <= 16'd2048;
      restart_q <= 1'b0;
    end else begin
      min_q     <= min_d;
      max_q     <= max_d;
      grow_q    <= grow_d;
      jit_q     <= jit_d;
      restart_q <= restart_d;
    end
  end

  assign cfg_o.min_interval    = min_q;
  assign cfg_o.max_interval    = max_q;
  assign cfg_o.growth_factor   = grow_q;
  assign cfg_o.jitter_fraction = jit_q;
  assign cfg_o.restart         = restart_q;

endmodule

// ----- rtl/bij_core.sv -----
module bij_core
  import bij_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            cmd_i,
  input  logic [FacW-1:0] random_fraction_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IvW-1:0]  resend_delay_o
);

  localparam int unsigned SumW = 39;  // signed I - half + offset

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MJ   = 6'b000010,  // I * J
    ST_MR   = 6'b000100,  // half * r
    ST_MB   = 6'b001000,  // I * B, delay clamp
    ST_GR   = 6'b010000,  // grow interval
    ST_OUT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [IvW-1:0]    iv_q, iv_d;
  logic [FacW-1:0]   rnd_q, rnd_d;
  logic [MulAW-1:0]  half_q, half_d;
  logic [IvW-1:0]    dly_q, dly_d;
  logic              out_valid_q, out_valid_d;
  logic [IvW-1:0]    out_q, out_d;

  logic              in_acc;
  logic              mul_en;
  logic [MulAW-1:0]  mul_a;
  logic [FacW-1:0]   mul_b;
  logic [MulPW-1:0]  prod;
  logic [36:0]       offset;
  logic [MulAW-1:0]  grown;
  logic [IvW-1:0]    grown_sat;
  logic signed [SumW-1:0] sum;

  function automatic logic [IvW-1:0] clamp_iv(input logic signed [SumW-1:0] x,
                                              input logic [IvW-1:0] lo,
                                              input logic [IvW-1:0] hi);
    logic signed [SumW-1:0] lo_s;
    logic signed [SumW-1:0] hi_s;
    logic signed [SumW-1:0] y;
    lo_s = $signed({7'b0, lo});
    hi_s = $signed({7'b0, hi});
    y = (x < lo_s) ? lo_s : x;
    y = (y > hi_s) ? hi_s : y;  // max applied last, so it wins
    return y[IvW-1:0];
  endfunction

  bij_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != ST_IDLE) || cfg_i.restart;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign offset    = prod[MulPW-1:15];
  assign grown     = prod[47:12];
  assign grown_sat = (|grown[MulAW-1:IvW]) ? {IvW{1'b1}} : grown[IvW-1:0];
  assign sum = $signed({7'b0, iv_q}) - $signed({3'b0, half_q}) + $signed({2'b0, offset});

  always_comb begin
    mul_en = 1'b0;
    mul_a  = {4'b0, iv_q};
    mul_b  = cfg_i.jitter_fraction;
    case (state_q)
      ST_MJ: mul_en = 1'b1;
      ST_MR: begin
        mul_en = 1'b1;
        mul_a  = prod[47:12];
        mul_b  = rnd_q;
      end
      ST_MB: begin
        mul_en = 1'b1;
        mul_b  = cfg_i.growth_factor;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    iv_d        = iv_q;
    rnd_d       = rnd_q;
    half_d      = half_q;
    dly_d       = dly_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cfg_i.restart) begin
      iv_d = cfg_i.min_interval;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(cmd_i) == CMD_RESET) begin
            iv_d = cfg_i.min_interval;
          end else begin
            rnd_d   = random_fraction_i;
            state_d = ST_MJ;
          end
        end
      end
      ST_MJ: state_d = ST_MR;
      ST_MR: begin
        half_d  = prod[47:12];
        state_d = ST_MB;
      end
      ST_MB: begin
        dly_d   = clamp_iv(sum, cfg_i.min_interval, cfg_i.max_interval);
        state_d = ST_GR;
      end
      ST_GR: begin
        iv_d    = clamp_iv($signed({7'b0, grown_sat}), cfg_i.min_interval,
                           cfg_i.max_interval);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = dly_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iv_q        <= 32'd32768;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iv_q        <= iv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q  <= rnd_d;
    half_q <= half_d;
    dly_q  <= dly_d;
    out_q  <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign resend_delay_o = out_q;

  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_e'(cmd_i) == CMD_DRAW) |=> state_q == ST_MJ)
    else $error("accepted draw did not start the multiply sequence");

  a_reset_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_e'(cmd_i) == CMD_RESET)
      |=> (state_q == ST_IDLE && iv_q == $past(cfg_i.min_interval)))
    else $error("reset command did not restore the minimum interval");

  a_beat_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result beat raised outside the output step");

  a_restart_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.restart |=> iv_q == $past(cfg_i.min_interval))
    else $error("register write did not restart the interval");

endmodule
